>>> rtl/core/humtf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humtf_pkg - shared types and constants of the humidity/temperature checker
// Word types of both channels, the frame record handed from the front to the
// back, the byte-position codes and the CRC-8 (0x31, MSB first) step.
// ----------------------------------------------------------------------------
package humtf_pkg;

	// CRC-8 polynomial and start value
	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	// conversion constants: 175/65536 degC scaled by 100, offset -45 degC
	localparam logic [14:0] TEMP_SCALE  = 15'd17500;
	localparam logic [15:0] TEMP_OFFSET = 16'd4500;
	localparam logic [13:0] HUM_SCALE   = 14'd10000;

	// product widths
	localparam int TEMP_PROD_W = 31;
	localparam int HUM_PROD_W  = 30;

	// input word
	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
	} in_word_t;

	// result word
	typedef struct packed {
		logic signed [14:0] temperature_centi;
		logic [13:0]        humidity_centi;
		logic               temp_crc_ok;
		logic               hum_crc_ok;
		logic               both_valid;
	} out_word_t;

	// completed frame, front to back
	typedef struct packed {
		logic [15:0] temp_raw;
		logic [15:0] hum_raw;
		logic        temp_ok;
		logic        hum_ok;
	} frame_t;

	// position of the next expected byte in the frame
	typedef enum logic [5:0] {
		POS_TH = 6'b000001,
		POS_TL = 6'b000010,
		POS_TC = 6'b000100,
		POS_HH = 6'b001000,
		POS_HL = 6'b010000,
		POS_HC = 6'b100000
	} pos_t;

	// one byte of CRC-8, MSB first
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

>>> rtl/core/humidity_temp_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_temp_frame_checker - CRC-checked humidity/temperature frame decoder
// Takes six sensor bytes per frame, checks both CRC-8 words and converts the
// raw readings to hundredths of a degree and of a percent.
//
//   channel | direction | handshake   | word
//   --------+-----------+-------------+-----------------------------
//   input   | in        | push / full | in_data  (byte, start mark)
//   result  | out       | empty / pop | out_data (temp, hum, flags)
//
// One byte is taken every cycle while full is low; the front does the CRC
// step in the cycle of acceptance. After the sixth byte, a result passes
// through the frame queue, the multiply stage and the output register.
// Full rises only when the frame queue (QUEUE_DEPTH frames) is full because
// results are not popped. Asynchronous reset returns to frame start with the
// CRC at 0xFF and no results waiting.
// ----------------------------------------------------------------------------
module humidity_temp_frame_checker #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  humtf_pkg::in_word_t  in_data,
	output logic                 empty,
	input  logic                 pop,
	output humtf_pkg::out_word_t out_data
);

	logic              take;
	logic              q_push;
	humtf_pkg::frame_t q_wr_data;
	logic              q_full;
	logic              q_pop;
	humtf_pkg::frame_t q_rd_data;
	logic              q_empty;

	assign full = q_full;
	assign take = push && !q_full;

	// byte tracking and CRC check
	humtf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.in_word     (in_data),
		.frame_valid (q_push),
		.frame       (q_wr_data)
	);

	// frame queue
	humtf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wr_data),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_rd_data),
		.empty   (q_empty)
	);

	// conversion and result register
	humtf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_avail (!q_empty),
		.frame       (q_rd_data),
		.frame_take  (q_pop),
		.pop         (pop),
		.empty       (empty),
		.out_word    (out_data)
	);

	// a finished frame never meets a full queue
	a_no_queue_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("frame queue overrun");

	// a failed temperature check shows a zero reading
	a_temp_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !out_data.temp_crc_ok) |-> (out_data.temperature_centi == '0))
		else $error("temperature not zero on CRC failure");

	// humidity stays below full scale
	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (out_data.humidity_centi <= 14'd9999))
		else $error("humidity out of range");

	// the combined flag agrees with both checks
	a_both_flag: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (out_data.both_valid == (out_data.temp_crc_ok && out_data.hum_crc_ok)))
		else $error("combined CRC flag mismatch");

endmodule

>>> rtl/core/humtf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humtf_front - byte tracker and CRC checker
// Follows the byte position in the frame, runs the CRC over each 16-bit word,
// compares it with the received CRC byte and hands a frame record onwards
// when the sixth byte arrives.
// ----------------------------------------------------------------------------
module humtf_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  humtf_pkg::in_word_t in_word,
	output logic              frame_valid,
	output humtf_pkg::frame_t frame
);

	humtf_pkg::pos_t pos_q;
	humtf_pkg::pos_t pos_d;
	humtf_pkg::pos_t pos_eff;
	logic [7:0]      crc_q;
	logic [7:0]      crc_d;
	logic [7:0]      crc_eff;
	logic [7:0]      crc_next;
	logic [15:0]     temp_raw_q;
	logic [15:0]     hum_raw_q;
	logic            temp_ok_q;
	logic            word_match;

	// start mark forces position and CRC back to frame start
	always_comb begin
		pos_eff    = in_word.frame_start ? humtf_pkg::POS_TH : pos_q;
		crc_eff    = in_word.frame_start ? humtf_pkg::CRC_INIT : crc_q;
		crc_next   = humtf_pkg::crc8_step(crc_eff, in_word.data_byte);
		word_match = (crc_eff == in_word.data_byte);
	end

	// next position and CRC
	always_comb begin
		frame_valid = 1'b0;
		unique case (pos_eff)
			humtf_pkg::POS_TL: begin
				pos_d = humtf_pkg::POS_TC;
				crc_d = crc_next;
			end
			humtf_pkg::POS_TC: begin
				pos_d = humtf_pkg::POS_HH;
				crc_d = humtf_pkg::CRC_INIT;
			end
			humtf_pkg::POS_HH: begin
				pos_d = humtf_pkg::POS_HL;
				crc_d = crc_next;
			end
			humtf_pkg::POS_HL: begin
				pos_d = humtf_pkg::POS_HC;
				crc_d = crc_next;
			end
			humtf_pkg::POS_HC: begin
				pos_d       = humtf_pkg::POS_TH;
				crc_d       = humtf_pkg::CRC_INIT;
				frame_valid = take;
			end
			default: begin
				// first byte, and any stray code
				pos_d = humtf_pkg::POS_TL;
				crc_d = crc_next;
			end
		endcase
	end

	assign frame.temp_raw = temp_raw_q;
	assign frame.hum_raw  = hum_raw_q;
	assign frame.temp_ok  = temp_ok_q;
	assign frame.hum_ok   = word_match;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= humtf_pkg::POS_TH;
			crc_q     <= humtf_pkg::CRC_INIT;
			temp_ok_q <= 1'b0;
		end else if (take) begin
			pos_q <= pos_d;
			crc_q <= crc_d;
			if (pos_eff == humtf_pkg::POS_TC) begin
				temp_ok_q <= word_match;
			end
		end
	end

	// raw words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_raw_q <= '0;
			hum_raw_q  <= '0;
		end else if (take) begin
			unique case (pos_eff)
				humtf_pkg::POS_TL: temp_raw_q[7:0]  <= in_word.data_byte;
				humtf_pkg::POS_HH: hum_raw_q[15:8]  <= in_word.data_byte;
				humtf_pkg::POS_HL: hum_raw_q[7:0]   <= in_word.data_byte;
				humtf_pkg::POS_TC, humtf_pkg::POS_HC: ;
				default:           temp_raw_q[15:8] <= in_word.data_byte;
			endcase
		end
	end

endmodule

>>> rtl/core/humtf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humtf_queue - short frame queue
// Small register queue between the front and the back, so that each side
// can stall on its own. Head entry is shown while empty is low.
// ----------------------------------------------------------------------------
module humtf_queue #(
	parameter int DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  humtf_pkg::frame_t wr_data,
	output logic              full,
	input  logic              rd_en,
	output humtf_pkg::frame_t rd_data,
	output logic              empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	humtf_pkg::frame_t   mem_q [DEPTH];
	logic [AW-1:0]       wr_ptr_q;
	logic [AW-1:0]       rd_ptr_q;
	logic [CW-1:0]       count_q;
	logic                do_wr;
	logic                do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/core/humtf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humtf_back - unit conversion and result register
// Stage 1 multiplies the raw words by the scale constants; the output stage
// takes the upper product bits, applies the temperature offset, zeroes a
// word whose CRC failed and holds the result until it is popped.
// ----------------------------------------------------------------------------
module humtf_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  frame_avail,
	input  humtf_pkg::frame_t     frame,
	output logic                  frame_take,
	input  logic                  pop,
	output logic                  empty,
	output humtf_pkg::out_word_t  out_word
);

	logic                                 valid_s1;
	logic [humtf_pkg::TEMP_PROD_W-1:0]    temp_prod_s1;
	logic [humtf_pkg::HUM_PROD_W-1:0]     hum_prod_s1;
	logic                                 temp_ok_s1;
	logic                                 hum_ok_s1;
	logic                                 out_valid_q;
	humtf_pkg::out_word_t                 out_q;
	humtf_pkg::out_word_t                 out_d;
	logic                                 adv_out;
	logic                                 adv_s1;
	logic [15:0]                          temp_off;

	// pipeline advance
	assign adv_out    = !out_valid_q || pop;
	assign adv_s1     = !valid_s1 || adv_out;
	assign frame_take = frame_avail && adv_s1;
	assign empty      = !out_valid_q;
	assign out_word   = out_q;

	// stage 1: scale multiplies
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= frame_avail;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_take) begin
			temp_prod_s1 <= humtf_pkg::TEMP_PROD_W'(frame.temp_raw)
				* humtf_pkg::TEMP_PROD_W'(humtf_pkg::TEMP_SCALE);
			hum_prod_s1  <= humtf_pkg::HUM_PROD_W'(frame.hum_raw)
				* humtf_pkg::HUM_PROD_W'(humtf_pkg::HUM_SCALE);
			temp_ok_s1   <= frame.temp_ok;
			hum_ok_s1    <= frame.hum_ok;
		end
	end

	// output stage: floor by dropping 16 bits, offset, CRC gating
	always_comb begin
		temp_off = {1'b0, temp_prod_s1[humtf_pkg::TEMP_PROD_W-1:16]} - humtf_pkg::TEMP_OFFSET;
		out_d.temperature_centi = temp_ok_s1 ? signed'(temp_off[14:0]) : '0;
		out_d.humidity_centi    = hum_ok_s1 ? hum_prod_s1[humtf_pkg::HUM_PROD_W-1:16] : '0;
		out_d.temp_crc_ok       = temp_ok_s1;
		out_d.hum_crc_ok        = hum_ok_s1;
		out_d.both_valid        = temp_ok_s1 && hum_ok_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && valid_s1) begin
			out_q <= out_d;
		end
	end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for humidity_temp_frame_checker
// Streams six-byte sensor frames (good, bad CRC, truncated, resynchronised and
// plain noise) into the byte queue and decodes each accepted byte in a local
// model of the frame checker. Every popped reading is compared field by field
// with the oldest predicted one. Sender gaps and receiver stalls vary by
// phase, with one long receiver hold-off and one pause that drains the block.
// ----------------------------------------------------------------------------
module tb;

	// conversion constants, hundredths
	localparam int T_SPAN_CENTI = 17500;
	localparam int T_OFFS_CENTI = 4500;
	localparam int H_SPAN_CENTI = 10000;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_BYTES  = 412;

	// position of the next byte within a frame
	typedef enum logic [2:0] {
		B_TH, B_TL, B_TC, B_HH, B_HL, B_HC
	} frame_slot_t;

	// word waiting to be sent; drain holds it back until no reading is due
	typedef struct {
		humtf_pkg::in_word_t w;
		bit                  drain;
	} queued_byte_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 push = 1'b0;
	logic                 full;
	humtf_pkg::in_word_t  in_data = '0;
	logic                 empty;
	logic                 pop = 1'b0;
	humtf_pkg::out_word_t out_data;

	queued_byte_t         byte_backlog[$];
	humtf_pkg::out_word_t expected_readings[$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;
	int bytes_queued   = 0;
	bit drain_next     = 1'b0;
	bit hold_on        = 1'b0;
	int hold_cnt       = 0;

	// local copy of the frame decoder state
	frame_slot_t slot      = B_TH;
	logic [7:0]  crc_acc   = humtf_pkg::CRC_INIT;
	logic [15:0] t_word    = '0;
	logic [15:0] h_word    = '0;
	logic        t_crc_ok  = 1'b0;

	humidity_temp_frame_checker u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_data  (in_data),
		.empty    (empty),
		.pop      (pop),
		.out_data (out_data)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// CRC-8, poly 0x31, one data bit at a time, MSB first
	function automatic logic [7:0] crc8_msb(input logic [7:0] c, input logic [7:0] b);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb = c[7] ^ b[i];
			c = {c[6:0], 1'b0} ^ (fb ? 8'h31 : 8'h00);
		end
		return c;
	endfunction

	// advance the local decoder by one accepted byte
	task automatic decode_sensor_byte(input humtf_pkg::in_word_t w);
		humtf_pkg::out_word_t r;
		logic [31:0]          t_prod;
		logic [31:0]          h_prod;
		int                   t_val;
		logic                 h_crc_ok;
		if (w.frame_start) begin
			slot = B_TH;
			crc_acc = humtf_pkg::CRC_INIT;
		end
		case (slot)
			B_TH: begin
				t_word[15:8] = w.data_byte;
				crc_acc = crc8_msb(crc_acc, w.data_byte);
				slot = B_TL;
			end
			B_TL: begin
				t_word[7:0] = w.data_byte;
				crc_acc = crc8_msb(crc_acc, w.data_byte);
				slot = B_TC;
			end
			B_TC: begin
				t_crc_ok = (crc_acc == w.data_byte);
				crc_acc = humtf_pkg::CRC_INIT;
				slot = B_HH;
			end
			B_HH: begin
				h_word[15:8] = w.data_byte;
				crc_acc = crc8_msb(crc_acc, w.data_byte);
				slot = B_HL;
			end
			B_HL: begin
				h_word[7:0] = w.data_byte;
				crc_acc = crc8_msb(crc_acc, w.data_byte);
				slot = B_HC;
			end
			default: begin
				h_crc_ok = (crc_acc == w.data_byte);
				t_prod = T_SPAN_CENTI * t_word;
				h_prod = H_SPAN_CENTI * h_word;
				t_val = int'(t_prod >> 16) - T_OFFS_CENTI;
				r.temperature_centi = t_crc_ok ? t_val[14:0] : '0;
				r.humidity_centi = h_crc_ok ? h_prod[29:16] : '0;
				r.temp_crc_ok = t_crc_ok;
				r.hum_crc_ok = h_crc_ok;
				r.both_valid = t_crc_ok & h_crc_ok;
				expected_readings.push_back(r);
				crc_acc = humtf_pkg::CRC_INIT;
				slot = B_TH;
			end
		endcase
	endtask

	task automatic queue_byte(input logic [7:0] b, input logic s);
		queued_byte_t q;
		q.w.data_byte = b;
		q.w.frame_start = s;
		q.drain = drain_next;
		drain_next = 1'b0;
		byte_backlog.push_back(q);
		bytes_queued++;
	endtask

	// frame of two CRC-protected words; keep < 6 gives a truncated frame
	task automatic queue_frame(input logic [15:0] t, input logic [15:0] h, input bit mark,
			input bit t_bad, input bit h_bad, input int keep);
		logic [7:0] fr[6];
		fr[0] = t[15:8];
		fr[1] = t[7:0];
		fr[2] = crc8_msb(crc8_msb(humtf_pkg::CRC_INIT, fr[0]), fr[1]);
		fr[3] = h[15:8];
		fr[4] = h[7:0];
		fr[5] = crc8_msb(crc8_msb(humtf_pkg::CRC_INIT, fr[3]), fr[4]);
		if (t_bad)
			fr[2] ^= 8'($urandom_range(1, 255));
		if (h_bad)
			fr[5] ^= 8'($urandom_range(1, 255));
		for (int i = 0; i < keep; i++)
			queue_byte(fr[i], (i == 0) ? mark : 1'b0);
	endtask

	// mostly random words, with the range ends now and then
	function automatic logic [15:0] pick_word();
		case ($urandom_range(9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// driver: holds a word until taken, then offers the next one
	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else if (!push || !full) begin
			if (push) begin
				decode_sensor_byte(in_data);
				void'(byte_backlog.pop_front());
			end
			if (byte_backlog.size() != 0
					&& !(byte_backlog[0].drain && expected_readings.size() != 0)
					&& $urandom_range(99) >= send_idle_pct) begin
				push <= 1'b1;
				in_data <= byte_backlog[0].w;
				byte_backlog[0].drain = 1'b0;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin
		if (hold_on && hold_cnt < HOLD_CYCLES)
			hold_cnt <= hold_cnt + 1;
	end

	// monitor: check each popped reading against the oldest prediction
	always @(posedge clk) begin
		humtf_pkg::out_word_t e;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_readings.size() == 0) begin
					$display("%0t: unexpected reading %h", $time, out_data);
					mismatch_count++;
				end else begin
					e = expected_readings.pop_front();
					if (out_data.temperature_centi !== e.temperature_centi) begin
						$display("%0t: temperature_centi expected %0d actual %0d", $time,
							e.temperature_centi, out_data.temperature_centi);
						mismatch_count++;
					end
					if (out_data.humidity_centi !== e.humidity_centi) begin
						$display("%0t: humidity_centi expected %0d actual %0d", $time,
							e.humidity_centi, out_data.humidity_centi);
						mismatch_count++;
					end
					if (out_data.temp_crc_ok !== e.temp_crc_ok) begin
						$display("%0t: temp_crc_ok expected %b actual %b", $time,
							e.temp_crc_ok, out_data.temp_crc_ok);
						mismatch_count++;
					end
					if (out_data.hum_crc_ok !== e.hum_crc_ok) begin
						$display("%0t: hum_crc_ok expected %b actual %b", $time,
							e.hum_crc_ok, out_data.hum_crc_ok);
						mismatch_count++;
					end
					if (out_data.both_valid !== e.both_valid) begin
						$display("%0t: both_valid expected %b actual %b", $time,
							e.both_valid, out_data.both_valid);
						mismatch_count++;
					end
				end
			end
			pop <= !(hold_on && hold_cnt < HOLD_CYCLES)
				&& $urandom_range(99) >= recv_stall_pct;
		end
	end

	// stimulus and end of run
	initial begin : stimulus
		int  phase_start;
		int  r;
		bit  mark_due;
		bit  drain_done;
		mark_due = 1'b0;
		drain_done = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// first frame with no start mark, then bad temperature CRC,
		// a frame cut short and resynchronised, then bad humidity CRC
		queue_frame(16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b0, 6);
		queue_frame(16'hFFFF, 16'h0000, 1'b1, 1'b1, 1'b0, 6);
		queue_frame(16'h1234, 16'h5678, 1'b1, 1'b0, 1'b0, 3);
		queue_frame(16'h8000, 16'h7FFF, 1'b1, 1'b0, 1'b1, 6);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_on = 1'b1; end
				1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
				default: begin send_idle_pct = 33; recv_stall_pct = 33; end
			endcase
			phase_start = bytes_queued;
			while (bytes_queued - phase_start < PHASE_BYTES) begin
				// one pause that lets the block run dry
				if (phase == 3 && !drain_done && bytes_queued - phase_start > 200) begin
					drain_next = 1'b1;
					drain_done = 1'b1;
				end
				r = $urandom_range(99);
				if (r < 78) begin
					queue_frame(pick_word(), pick_word(),
						mark_due | ($urandom_range(1) == 1),
						$urandom_range(7) == 0, $urandom_range(7) == 0, 6);
					mark_due = 1'b0;
				end else if (r < 90) begin
					queue_frame(pick_word(), pick_word(), $urandom_range(3) != 0,
						1'b0, 1'b0, $urandom_range(1, 5));
					mark_due = 1'b1;
				end else begin
					repeat ($urandom_range(1, 8))
						queue_byte(8'($urandom), $urandom_range(3) == 0);
					mark_due = 1'b1;
				end
			end
			while (byte_backlog.size() != 0 || push)
				@(negedge clk);
		end

		while (expected_readings.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// watchdog
	initial begin
		#400000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
